>>> rtl/core/spe_pkg.sv
// shared constants, opcodes and sequencer states for the stack p-code execute unit
// no dependencies
package spe_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int WORD_BITS_DEF   = 32;
  localparam int PC_BITS_DEF     = 16;

  // signed width for pointer and index arithmetic, wide enough for any word value
  localparam int IDX_W = 66;

  localparam logic [4:0] OP_PUSH = 5'd0;
  localparam logic [4:0] OP_POP  = 5'd1;
  localparam logic [4:0] OP_ADD  = 5'd2;
  localparam logic [4:0] OP_SUB  = 5'd3;
  localparam logic [4:0] OP_MUL  = 5'd4;
  localparam logic [4:0] OP_DIV  = 5'd5;
  localparam logic [4:0] OP_EQ   = 5'd6;
  localparam logic [4:0] OP_NEQ  = 5'd7;
  localparam logic [4:0] OP_LT   = 5'd8;
  localparam logic [4:0] OP_LE   = 5'd9;
  localparam logic [4:0] OP_GT   = 5'd10;
  localparam logic [4:0] OP_GE   = 5'd11;
  localparam logic [4:0] OP_AND  = 5'd12;
  localparam logic [4:0] OP_OR   = 5'd13;
  localparam logic [4:0] OP_JUMP = 5'd14;
  localparam logic [4:0] OP_BRCT = 5'd15;
  localparam logic [4:0] OP_BRCF = 5'd16;
  localparam logic [4:0] OP_CALL = 5'd17;
  localparam logic [4:0] OP_RET  = 5'd18;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_PUSHW, S_POPW, S_BIN1, S_BIN2, S_EXEC, S_DIV, S_BRW,
    S_CALL0, S_CALL1, S_CALL2, S_RET1, S_RET2, S_RET3, S_RET4, S_RET5,
    S_TOP, S_TOPW, S_OUT
  } st_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/core/spe_if.sv
// valid/ready channel interfaces for instruction beats and result beats
// depends on nothing
interface spe_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         cmd;
  logic signed [31:0] operand;
  logic               is_immediate;
  logic [5:0]         arg_count;
  logic [5:0]         var_count;

  modport source (output valid, cmd, operand, is_immediate, arg_count, var_count,
                  input ready);
  modport sink (input valid, cmd, operand, is_immediate, arg_count, var_count,
                output ready);
endinterface

interface spe_out_if #(
  parameter int WORD_BITS = 32,
  parameter int PC_BITS   = 16
);
  logic                        valid;
  logic                        ready;
  logic [PC_BITS-1:0]          next_pc;
  logic signed [WORD_BITS-1:0] top_value;
  logic signed [7:0]           stack_top_index;
  logic signed [WORD_BITS-1:0] bottom_value;
  logic                        halted;
  logic                        overflow;
  logic                        div_zero;

  modport source (output valid, next_pc, top_value, stack_top_index, bottom_value,
                  halted, overflow, div_zero, input ready);
  modport sink (input valid, next_pc, top_value, stack_top_index, bottom_value,
                halted, overflow, div_zero, output ready);
endinterface

>>> rtl/core/spe_stack_mem.sv
// stack word memory, one write and one registered read port, valid bit per entry
// depends on spe_pkg
module spe_stack_mem
  import spe_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  parameter int W     = WORD_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  input  logic          rok,
  output logic [W-1:0]  rdata,
  output logic [W-1:0]  bottom
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [W-1:0]     mem_q_r;
  logic             sel_r;
  logic [W-1:0]     bottom_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      sel_r    <= 1'b0;
      bottom_r <= '0;
    end else begin
      sel_r <= rok && valid_r[raddr];
      if (we) begin
        valid_r[waddr] <= 1'b1;
        if (waddr == '0) begin
          bottom_r <= wdata;
        end
      end
    end
  end

  // unwritten or out-of-range entries read as zero
  assign rdata  = sel_r ? mem_q_r : '0;
  assign bottom = bottom_r;

endmodule

>>> rtl/core/spe_divider.sv
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// depends on spe_pkg
module spe_divider
  import spe_pkg::*;
#(
  parameter int W = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output div_status_t  status
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, q_r, d_r;
  logic          neg_r, busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [W:0]    shifted, diff;

  assign shifted = {rem_r, q_r[W-1]};
  assign diff    = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
        rem_r  <= '0;
        q_r    <= dividend[W-1] ? (~dividend + W'(1)) : dividend;
        d_r    <= divisor[W-1] ? (~divisor + W'(1)) : divisor;
        neg_r  <= dividend[W-1] ^ divisor[W-1];
      end else if (busy_r) begin
        if (!diff[W]) begin
          rem_r <= diff[W-1:0];
          q_r   <= {q_r[W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[W-1:0];
          q_r   <= {q_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient    = neg_r ? (~q_r + W'(1)) : q_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

>>> rtl/core/stack_pcode_execute_unit.sv
// top level of the stack p-code execute unit: sequencer, alu and pointer registers
// depends on spe_pkg, spe_if, spe_stack_mem and spe_divider
//
//  channel | dir | beat contents
//  in_ch   | in  | cmd, operand, is_immediate, arg_count, var_count
//  out_ch  | out | next_pc, top_value, stack_top_index, bottom_value, flags
//
// one instruction at a time: in_ch.ready is high only when the sequencer is idle
// from the accepting edge the sequencer passes decode, the op's own states and a top-of-stack
// read before out valid; the single read port gives each stack read a state of its own, and a
// divide waits in S_DIV for the bit-serial divider
// a result beat holds until out_ch.ready; the next instruction is taken after that
// reset clears the stack valid bits at once, so no clearing pass is needed
module stack_pcode_execute_unit
  import spe_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF,
  parameter int PC_BITS     = PC_BITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  spe_in_if.sink  in_ch,
  spe_out_if.source out_ch
);

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int BP_W = $clog2(STACK_DEPTH + 1);
  localparam int SP_W = BP_W + 1;

  localparam logic signed [IDX_W-1:0] NEG_ONE = '1;
  localparam logic signed [IDX_W-1:0] ZERO_X  = '0;
  localparam logic signed [IDX_W-1:0] ONE_X   = IDX_W'(1);
  localparam logic signed [IDX_W-1:0] DEPTH_X = IDX_W'(STACK_DEPTH);

  function automatic logic signed [IDX_W-1:0] clamp(input logic signed [IDX_W-1:0] v,
                                                    input logic signed [IDX_W-1:0] lo,
                                                    input logic signed [IDX_W-1:0] hi);
    logic signed [IDX_W-1:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  st_t                    state_r, state_nxt;
  logic [4:0]             cmd_r, cmd_nxt;
  logic signed [31:0]     op_r, op_nxt;
  logic                   imm_r, imm_nxt;
  logic [5:0]             args_r, args_nxt, vars_r, vars_nxt;
  logic signed [SP_W-1:0] sp_r, sp_nxt;
  logic [BP_W-1:0]        bp_r, bp_nxt;
  logic [PC_BITS-1:0]     pc_r, pc_nxt;
  logic signed [IDX_W-1:0] wp_r, wp_nxt;
  logic [WORD_BITS-1:0]   a_r, a_nxt, b_r, b_nxt, top_r, top_nxt;
  logic                   ovf_r, ovf_nxt, dz_r, dz_nxt;

  // memory request
  logic signed [IDX_W-1:0] rd_idx, wr_idx;
  logic                    wr_en;
  logic [WORD_BITS-1:0]    wr_data, rdata, bottom, alu, quot;
  logic                    div_start;
  div_status_t             div_st;

  logic signed [IDX_W-1:0] sp_x, bp_x, op_x, args_x, vars_x, rd_x;
  logic                    take;

  assign sp_x   = IDX_W'(sp_r);
  assign bp_x   = IDX_W'(bp_r);
  assign op_x   = IDX_W'(op_r);
  assign args_x = IDX_W'(args_r);
  assign vars_x = IDX_W'(vars_r);
  assign rd_x   = IDX_W'($signed(rdata));

  spe_stack_mem #(.DEPTH(STACK_DEPTH), .W(WORD_BITS)) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (wr_en && (wr_idx >= ZERO_X) && (wr_idx < DEPTH_X)),
    .waddr  (wr_idx[AW-1:0]),
    .wdata  (wr_data),
    .raddr  (rd_idx[AW-1:0]),
    .rok    ((rd_idx >= ZERO_X) && (rd_idx < DEPTH_X)),
    .rdata  (rdata),
    .bottom (bottom)
  );

  spe_divider #(.W(WORD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (a_r),
    .divisor  (b_r),
    .quotient (quot),
    .status   (div_st)
  );

  // combinational alu on the second-from-top (a) and top (b) words, for every binary op but divide
  always_comb begin
    case (cmd_r)
      OP_ADD:  alu = a_r + b_r;
      OP_SUB:  alu = a_r - b_r;
      OP_MUL:  alu = a_r * b_r;
      OP_EQ:   alu = WORD_BITS'(a_r == b_r);
      OP_NEQ:  alu = WORD_BITS'(a_r != b_r);
      OP_LT:   alu = WORD_BITS'($signed(a_r) <  $signed(b_r));
      OP_LE:   alu = WORD_BITS'($signed(a_r) <= $signed(b_r));
      OP_GT:   alu = WORD_BITS'($signed(a_r) >  $signed(b_r));
      OP_GE:   alu = WORD_BITS'($signed(a_r) >= $signed(b_r));
      OP_AND:  alu = WORD_BITS'((a_r != '0) && (b_r != '0));
      default: alu = WORD_BITS'((a_r != '0) || (b_r != '0));
    endcase
  end

  // branch condition on the top word just read
  assign take = (cmd_r == OP_BRCT) ? (rdata == WORD_BITS'(1)) : (rdata == '0);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    op_nxt    = op_r;
    imm_nxt   = imm_r;
    args_nxt  = args_r;
    vars_nxt  = vars_r;
    sp_nxt    = sp_r;
    bp_nxt    = bp_r;
    pc_nxt    = pc_r;
    wp_nxt    = wp_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    top_nxt   = top_r;
    ovf_nxt   = ovf_r;
    dz_nxt    = dz_r;
    rd_idx    = wp_r;
    wr_en     = 1'b0;
    wr_idx    = wp_r;
    wr_data   = '0;
    div_start = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          op_nxt    = in_ch.operand;
          imm_nxt   = in_ch.is_immediate;
          args_nxt  = in_ch.arg_count;
          vars_nxt  = in_ch.var_count;
          ovf_nxt   = 1'b0;
          dz_nxt    = 1'b0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sp_x >= DEPTH_X) begin
          // stack full: drop the instruction, reset pointers, halt
          ovf_nxt   = 1'b1;
          sp_nxt    = SP_W'(NEG_ONE);
          bp_nxt    = '0;
          pc_nxt    = PC_BITS'(1);
          state_nxt = S_TOP;
        end else begin
          case (cmd_r)
            OP_PUSH: begin
              if (imm_r) begin
                wr_en     = 1'b1;
                wr_idx    = sp_x + ONE_X;
                wr_data   = WORD_BITS'(op_r);
                sp_nxt    = SP_W'(clamp(sp_x + ONE_X, NEG_ONE, DEPTH_X));
                pc_nxt    = pc_r + PC_BITS'(1);
                state_nxt = S_TOP;
              end else begin
                rd_idx    = bp_x + op_x;
                state_nxt = S_PUSHW;
              end
            end
            OP_POP: begin
              rd_idx    = sp_x;
              state_nxt = S_POPW;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NEQ,
            OP_LT, OP_LE, OP_GT, OP_GE, OP_AND, OP_OR: begin
              rd_idx    = sp_x - ONE_X;
              state_nxt = S_BIN1;
            end
            OP_JUMP: begin
              pc_nxt    = pc_r + PC_BITS'(op_r);
              state_nxt = S_TOP;
            end
            OP_BRCT, OP_BRCF: begin
              rd_idx    = sp_x;
              state_nxt = S_BRW;
            end
            OP_CALL: begin
              wp_nxt    = sp_x + vars_x - args_x;
              state_nxt = S_CALL0;
            end
            OP_RET: begin
              rd_idx    = sp_x;
              state_nxt = S_RET1;
            end
            default: begin
              pc_nxt    = pc_r + PC_BITS'(1);
              state_nxt = S_TOP;
            end
          endcase
        end
      end
      S_PUSHW: begin
        wr_en     = 1'b1;
        wr_idx    = sp_x + ONE_X;
        wr_data   = rdata;
        sp_nxt    = SP_W'(clamp(sp_x + ONE_X, NEG_ONE, DEPTH_X));
        pc_nxt    = pc_r + PC_BITS'(1);
        state_nxt = S_TOP;
      end
      S_POPW: begin
        wr_en     = 1'b1;
        wr_idx    = bp_x + op_x;
        wr_data   = rdata;
        sp_nxt    = SP_W'(clamp(sp_x - ONE_X, NEG_ONE, DEPTH_X));
        pc_nxt    = pc_r + PC_BITS'(1);
        state_nxt = S_TOP;
      end
      S_BIN1: begin
        a_nxt     = rdata;
        rd_idx    = sp_x;
        state_nxt = S_BIN2;
      end
      S_BIN2: begin
        b_nxt     = rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if ((cmd_r == OP_DIV) && (b_r != '0)) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          wr_en     = 1'b1;
          wr_idx    = sp_x - ONE_X;
          wr_data   = (cmd_r == OP_DIV) ? '0 : alu;
          dz_nxt    = (cmd_r == OP_DIV);
          sp_nxt    = SP_W'(clamp(sp_x - ONE_X, NEG_ONE, DEPTH_X));
          pc_nxt    = pc_r + PC_BITS'(1);
          state_nxt = S_TOP;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          wr_en     = 1'b1;
          wr_idx    = sp_x - ONE_X;
          wr_data   = quot;
          sp_nxt    = SP_W'(clamp(sp_x - ONE_X, NEG_ONE, DEPTH_X));
          pc_nxt    = pc_r + PC_BITS'(1);
          state_nxt = S_TOP;
        end
      end
      S_BRW: begin
        pc_nxt    = take ? (pc_r + PC_BITS'(op_r)) : (pc_r + PC_BITS'(1));
        sp_nxt    = SP_W'(clamp(sp_x - ONE_X, NEG_ONE, DEPTH_X));
        state_nxt = S_TOP;
      end
      // frame: old sp, return pc, old bp above the callee's variables
      S_CALL0: begin
        wr_en     = 1'b1;
        wr_idx    = wp_r + ONE_X;
        wr_data   = WORD_BITS'(sp_r);
        state_nxt = S_CALL1;
      end
      S_CALL1: begin
        wr_en     = 1'b1;
        wr_idx    = wp_r + IDX_W'(2);
        wr_data   = WORD_BITS'(pc_r);
        state_nxt = S_CALL2;
      end
      S_CALL2: begin
        wr_en     = 1'b1;
        wr_idx    = wp_r + IDX_W'(3);
        wr_data   = WORD_BITS'(bp_r);
        bp_nxt    = BP_W'(clamp(sp_x + ONE_X - args_x, ZERO_X, DEPTH_X));
        sp_nxt    = SP_W'(clamp(wp_r + IDX_W'(3), NEG_ONE, DEPTH_X));
        pc_nxt    = pc_r + PC_BITS'(op_r);
        state_nxt = S_TOP;
      end
      // return value goes to the frame base before the frame is read back
      S_RET1: begin
        wr_en     = 1'b1;
        wr_idx    = bp_x;
        wr_data   = rdata;
        wp_nxt    = sp_x - ONE_X;
        state_nxt = S_RET2;
      end
      S_RET2: begin
        rd_idx    = wp_r;
        state_nxt = S_RET3;
      end
      S_RET3: begin
        bp_nxt    = BP_W'(clamp(rd_x, ZERO_X, DEPTH_X));
        wp_nxt    = wp_r - ONE_X;
        rd_idx    = wp_r - ONE_X;
        state_nxt = S_RET4;
      end
      S_RET4: begin
        pc_nxt    = PC_BITS'($signed(rdata)) + PC_BITS'(1);
        wp_nxt    = wp_r - ONE_X;
        rd_idx    = wp_r - ONE_X;
        state_nxt = S_RET5;
      end
      S_RET5: begin
        sp_nxt    = SP_W'(clamp(rd_x, NEG_ONE, DEPTH_X));
        state_nxt = S_TOP;
      end
      S_TOP: begin
        rd_idx    = sp_x;
        state_nxt = S_TOPW;
      end
      S_TOPW: begin
        top_nxt   = rdata;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= SP_W'(NEG_ONE);
      bp_r    <= '0;
      pc_r    <= '0;
      ovf_r   <= 1'b0;
      dz_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      bp_r    <= bp_nxt;
      pc_r    <= pc_nxt;
      ovf_r   <= ovf_nxt;
      dz_r    <= dz_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    op_r   <= op_nxt;
    imm_r  <= imm_nxt;
    args_r <= args_nxt;
    vars_r <= vars_nxt;
    wp_r   <= wp_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    top_r  <= top_nxt;
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = (state_r == S_OUT);
  assign out_ch.next_pc         = pc_r;
  assign out_ch.top_value       = top_r;
  assign out_ch.stack_top_index = 8'(sp_r);
  assign out_ch.bottom_value    = bottom;
  assign out_ch.halted          = (pc_r == PC_BITS'(1));
  assign out_ch.overflow        = ovf_r;
  assign out_ch.div_zero        = dz_r;

  // an accepted beat always starts decode
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_DEC))
    else $error("accepted beat did not enter decode");

  // overflow always leaves the block halted with an empty stack
  a_ovf_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ovf_r) |-> (out_ch.halted && (sp_r == SP_W'(NEG_ONE))))
    else $error("overflow without halt and empty stack");

  // divider only runs and finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (div_st.busy || div_st.done) |-> (state_r == S_DIV))
    else $error("divider active outside divide wait");

  // stack pointer stays inside its saturation range
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((sp_x >= NEG_ONE) && (sp_x <= DEPTH_X)))
    else $error("stack pointer out of range");

endmodule

>>> tb/stack_pcode_execute_unit_test.sv
// self-checking testbench for the stack p-code execute unit: random and directed programs
// depends on spe_pkg, spe_if and the execute unit rtl
module stack_pcode_execute_unit_test
  import spe_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic [4:0]         cmd;
    logic signed [31:0] operand;
    logic               is_immediate;
    logic [5:0]         arg_count;
    logic [5:0]         var_count;
  } instr_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic signed [31:0] top_value;
    logic signed [7:0]  stack_top_index;
    logic signed [31:0] bottom_value;
    logic               halted;
    logic               overflow;
    logic               div_zero;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  spe_in_if  in_ch ();
  spe_out_if #(.WORD_BITS(32), .PC_BITS(16)) out_ch ();

  stack_pcode_execute_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // shadow machine state
  logic [31:0]       mdl_stack [DEPTH];
  longint            mdl_sp;
  longint            mdl_bp;
  logic [15:0]       mdl_pc;

  instr_t  pending_instrs [$];
  status_t expected_status [$];
  int      errors = 0;
  int      cycles = 0;
  bit      sender_pause = 1'b0;
  int      hold_cycles = 0;

  function automatic logic [31:0] stack_rd(longint idx);
    if (idx < 0 || idx >= DEPTH) return 32'd0;
    return mdl_stack[idx];
  endfunction

  function automatic void stack_wr(longint idx, logic [31:0] v);
    if (idx >= 0 && idx < DEPTH) mdl_stack[idx] = v;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] alu_result(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                                            inout bit dz);
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    sa = a;
    sb = b;
    case (op)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIV: begin
        if (sb == 0) begin
          dz = 1'b1;
          return 32'd0;
        end
        if (sb == -1) return 32'd0 - a;
        return sa / sb;
      end
      OP_EQ:  return {31'd0, sa == sb};
      OP_NEQ: return {31'd0, sa != sb};
      OP_LT:  return {31'd0, sa < sb};
      OP_LE:  return {31'd0, sa <= sb};
      OP_GT:  return {31'd0, sa > sb};
      OP_GE:  return {31'd0, sa >= sb};
      OP_AND: return {31'd0, (sa != 0) && (sb != 0)};
      default: return {31'd0, (sa != 0) || (sb != 0)};
    endcase
  endfunction

  // advance the shadow machine by one instruction and return its status beat
  function automatic status_t execute_instr(instr_t ins);
    status_t st;
    bit      ovf;
    bit      dz;
    longint  sp;
    longint  bp;
    longint  old_sp;
    longint  old_bp;
    longint  opnd;
    logic [15:0] pc;
    logic signed [31:0] t;
    bit      take;
    ovf = 1'b0;
    dz = 1'b0;
    sp = mdl_sp;
    bp = mdl_bp;
    pc = mdl_pc;
    opnd = ins.operand;
    if (sp >= DEPTH) begin
      // overflow: instruction dropped, pointers back to start, halt
      ovf = 1'b1;
      sp = -1;
      bp = 0;
      pc = 16'd1;
    end else begin
      case (ins.cmd)
        OP_PUSH: begin
          stack_wr(sp + 1, ins.is_immediate ? ins.operand : stack_rd(bp + opnd));
          sp++;
          pc++;
        end
        OP_POP: begin
          stack_wr(bp + opnd, stack_rd(sp));
          sp--;
          pc++;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NEQ, OP_LT, OP_LE, OP_GT, OP_GE,
        OP_AND, OP_OR: begin
          stack_wr(sp - 1, alu_result(ins.cmd, stack_rd(sp - 1), stack_rd(sp), dz));
          sp--;
          pc++;
        end
        OP_JUMP: pc = pc + ins.operand[15:0];
        OP_BRCT, OP_BRCF: begin
          t = stack_rd(sp);
          take = (ins.cmd == OP_BRCT) ? (t == 1) : (t == 0);
          if (take) pc = pc + ins.operand[15:0];
          else pc++;
          sp--;
        end
        OP_CALL: begin
          old_sp = sp;
          old_bp = bp;
          bp = clamp_to(sp + 1 - longint'(ins.arg_count), 0, DEPTH);
          sp = sp + longint'(ins.var_count) - longint'(ins.arg_count);
          stack_wr(sp + 1, old_sp[31:0]);
          stack_wr(sp + 2, {16'd0, pc});
          stack_wr(sp + 3, old_bp[31:0]);
          sp += 3;
          pc = pc + ins.operand[15:0];
        end
        OP_RET: begin
          stack_wr(bp, stack_rd(sp));
          sp--;
          bp = clamp_to(longint'($signed(stack_rd(sp))), 0, DEPTH);
          sp--;
          pc = stack_rd(sp) + 32'd1;
          sp--;
          sp = longint'($signed(stack_rd(sp)));
        end
        default: pc++;  // nop and unused opcodes
      endcase
      sp = clamp_to(sp, -1, DEPTH);
    end
    mdl_sp = sp;
    mdl_bp = bp;
    mdl_pc = pc;
    st.next_pc = pc;
    st.top_value = stack_rd(sp);
    st.stack_top_index = sp[7:0];
    st.bottom_value = stack_rd(0);
    st.halted = (pc == 16'd1);
    st.overflow = ovf;
    st.div_zero = dz;
    return st;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  function automatic instr_t mk(logic [4:0] c, logic [31:0] o, bit imm = 1'b1,
                                logic [5:0] a = 6'd0, logic [5:0] v = 6'd0);
    instr_t i;
    i.cmd = c;
    i.operand = o;
    i.is_immediate = imm;
    i.arg_count = a;
    i.var_count = v;
    return i;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 7) - 3;
      default: return $urandom();
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t i;
    i = mk(5'($urandom_range(0, 19)), rand_word(), 1'($urandom()),
           6'($urandom_range(0, 3)), 6'($urandom_range(0, 4)));
    // mostly small frame offsets so pushes and pops land inside the stack
    if ((i.cmd == OP_PUSH && !i.is_immediate) || i.cmd == OP_POP)
      if ($urandom_range(0, 3) != 0) i.operand = $urandom_range(0, 8) - 2;
    if (i.cmd inside {OP_JUMP, OP_BRCT, OP_BRCF, OP_CALL} && $urandom_range(0, 2) != 0)
      i.operand = $urandom_range(0, 20) - 10;
    if ($urandom_range(0, 15) == 0) begin
      i.arg_count = 6'($urandom());
      i.var_count = 6'($urandom());
    end
    if ($urandom_range(0, 30) == 0) i.cmd = 5'($urandom_range(20, 31));
    // bias toward pushes so the stack fills and overflow is reached
    if ($urandom_range(0, 3) == 0) i.cmd = OP_PUSH;
    return i;
  endfunction

  // driver: one beat at a time with random gaps
  int gap_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the beat
    end else begin
      if (in_ch.valid) gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      if (gap_left > 0 || sender_pause || pending_instrs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        instr_t nx;
        nx = pending_instrs.pop_front();
        expected_status.push_back(execute_instr(nx));
        in_ch.valid <= 1'b1;
        in_ch.cmd <= nx.cmd;
        in_ch.operand <= nx.operand;
        in_ch.is_immediate <= nx.is_immediate;
        in_ch.arg_count <= nx.arg_count;
        in_ch.var_count <= nx.var_count;
      end
    end
  end

  // receiver stall, with a long hold-off counted here
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      out_ch.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= (stall_left == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        status_t w;
        w = expected_status.pop_front();
        if (out_ch.next_pc !== w.next_pc) report_mismatch("next_pc", out_ch.next_pc, w.next_pc);
        if (out_ch.top_value !== w.top_value)
          report_mismatch("top_value", out_ch.top_value, w.top_value);
        if (out_ch.stack_top_index !== w.stack_top_index)
          report_mismatch("stack_top_index", out_ch.stack_top_index, w.stack_top_index);
        if (out_ch.bottom_value !== w.bottom_value)
          report_mismatch("bottom_value", out_ch.bottom_value, w.bottom_value);
        if (out_ch.halted !== w.halted) report_mismatch("halted", out_ch.halted, w.halted);
        if (out_ch.overflow !== w.overflow)
          report_mismatch("overflow", out_ch.overflow, w.overflow);
        if (out_ch.div_zero !== w.div_zero)
          report_mismatch("div_zero", out_ch.div_zero, w.div_zero);
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.operand = '0;
    in_ch.is_immediate = 1'b0;
    in_ch.arg_count = '0;
    in_ch.var_count = '0;
    out_ch.ready = 1'b0;
    for (int k = 0; k < DEPTH; k++) mdl_stack[k] = '0;
    mdl_sp = -1;
    mdl_bp = 0;
    mdl_pc = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: arithmetic extremes, divide special cases, compares, call/ret
    pending_instrs.push_back(mk(OP_ADD, 32'd0));                 // binop on empty stack
    pending_instrs.push_back(mk(OP_PUSH, 32'h8000_0000));
    pending_instrs.push_back(mk(OP_PUSH, 32'hffff_ffff));
    pending_instrs.push_back(mk(OP_DIV, 32'd0));                 // most negative / -1
    pending_instrs.push_back(mk(OP_PUSH, 32'd0));
    pending_instrs.push_back(mk(OP_DIV, 32'd0));                 // divide by zero
    pending_instrs.push_back(mk(OP_PUSH, 32'h7fff_ffff));
    pending_instrs.push_back(mk(OP_PUSH, 32'd7));
    pending_instrs.push_back(mk(OP_SUB, 32'd0));
    pending_instrs.push_back(mk(OP_PUSH, 32'hffff_fff9));
    pending_instrs.push_back(mk(OP_MUL, 32'd0));
    pending_instrs.push_back(mk(OP_PUSH, 32'd3));
    pending_instrs.push_back(mk(OP_LT, 32'd0));
    pending_instrs.push_back(mk(OP_PUSH, 32'd1, 1'b0));          // frame slot push
    pending_instrs.push_back(mk(OP_PUSH, 32'd5));
    pending_instrs.push_back(mk(OP_CALL, 32'd10, 1'b1, 6'd1, 6'd2));
    pending_instrs.push_back(mk(OP_PUSH, 32'd42));
    pending_instrs.push_back(mk(OP_RET, 32'd0));
    pending_instrs.push_back(mk(OP_BRCT, 32'hffff_fffe));
    pending_instrs.push_back(mk(OP_POP, 32'd100));               // out-of-range write
    pending_instrs.push_back(mk(OP_JUMP, 32'hffff_ffff));
    pending_instrs.push_back(mk(OP_BRCF, 32'd4));
    pending_instrs.push_back(mk(5'd31, 32'd0));
    pending_instrs.push_back(mk(OP_CALL, 32'h7fff_ffff, 1'b0, 6'd63, 6'd63));
    wait (pending_instrs.size() == 0 && expected_status.size() == 0);

    // random programs, with a receiver hold-off and a sender drain pause
    for (int n = 0; n < 1830; n++) begin
      pending_instrs.push_back(rand_instr());
      if (n == 600) begin
        wait (pending_instrs.size() == 0);
        hold_cycles = 300;
      end
      if (n == 1200) begin
        wait (pending_instrs.size() == 0);
        sender_pause = 1'b1;
        wait (expected_status.size() == 0);
        sender_pause = 1'b0;
      end
    end
    wait (pending_instrs.size() == 0 && !in_ch.valid);
    wait (expected_status.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
